// ===== sv/elcb_pkg.sv =====
// Shared types and constants for the encoder level control and bar graph block.
`timescale 1ns / 1ps

package elcb_pkg;

	localparam int unsigned LevelW  = 7;
	localparam int unsigned BarW    = 10;
	localparam int unsigned DeltaW  = 16;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDatW = 8;

	localparam logic [LevelW-1:0] LevelMax   = 7'd100;
	localparam logic [LevelW-1:0] LevelReset = 7'd50;
	localparam logic [7:0]        ThrReset   = 8'd4;
	localparam logic [6:0]        StepReset  = 7'd4;

	typedef enum logic [1:0] {
		MODE_LINEAR = 2'd0,
		MODE_THRESH = 2'd1,
		MODE_SINGLE = 2'd2
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MODE       = 2'd0,
		REG_THRESHOLD  = 2'd1,
		REG_STEP       = 2'd2,
		REG_START      = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  accel_threshold;
		logic [6:0]  coarse_step;
		logic [6:0]  start_level;
	} cfg_t;

	typedef struct packed {
		logic                     kind;
		logic signed [DeltaW-1:0] delta;
	} req_t;

	typedef struct packed {
		logic [LevelW-1:0] level;
		logic [BarW-1:0]   led_bar;
	} res_t;

endpackage

// ===== sv/encoder_level_control_bargraph_top.sv =====
// Top level of the encoder level control with bar graph output.
`timescale 1ns / 1ps
// Request channel (req_valid, req_stall, req_data): kind 0 moves the level by
// the signed encoder delta according to the mode register, kind 1 reloads the
// start level (clamped to 100). Every request yields exactly one result on the
// result channel (res_valid, res_stall, res_data) carrying the new level and
// the 10-LED bar graph.
// A request is registered on acceptance, the next level is formed in one pass
// of multiply, add and clamp against the held level, and written to the
// result register once that is empty or being drained; res_valid rises as
// the result register is loaded, and the result is taken when not stalled.
// One request per cycle is taken unless stalled; the level register feeds
// back in the same cycle, so consecutive requests never wait on each other.
// When the receiver stalls, the result is held and the input register still
// takes one more request; req_stall rises only once both are full.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// ready and must only be issued while no request is in flight.
// Reset empties both registers, sets the level to 50 and the registers to
// mode linear, threshold 4, coarse step 4, start level 50.

module encoder_level_control_bargraph_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  elcb_pkg::req_t                req_data,
	output logic                          res_valid,
	input  logic                          res_stall,
	output elcb_pkg::res_t                res_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [elcb_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [elcb_pkg::CfgDatW-1:0]  cfg_data
);
	import elcb_pkg::*;

	cfg_t              cfg_q;
	req_t              req_s1;
	logic              vld_s1;
	res_t              res_s2;
	logic              vld_s2;
	logic [LevelW-1:0] level_q;
	res_t              step_res;
	logic              adv;
	logic              take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode            <= MODE_LINEAR;
			cfg_q.accel_threshold <= ThrReset;
			cfg_q.coarse_step     <= StepReset;
			cfg_q.start_level     <= LevelReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_MODE:      cfg_q.mode            <= mode_t'(cfg_data[1:0]);
				REG_THRESHOLD: cfg_q.accel_threshold <= cfg_data;
				REG_STEP:      cfg_q.coarse_step     <= cfg_data[6:0];
				REG_START:     cfg_q.start_level     <= cfg_data[6:0];
			endcase
		end
	end

	// s1 moves on when the result register is empty or being drained
	assign adv       = vld_s1 && (!vld_s2 || !res_stall);
	assign req_stall = vld_s1 && !adv;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (take)
			vld_s1 <= 1'b1;
		else if (adv)
			vld_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			req_s1 <= req_data;
	end

	elcb_step u_step (
		.level (level_q),
		.req   (req_s1),
		.cfg   (cfg_q),
		.res   (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			level_q <= LevelReset;
		end else if (adv) begin
			vld_s2  <= 1'b1;
			level_q <= step_res.level;
		end else if (!res_stall) begin
			vld_s2  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= step_res;
	end

	assign res_valid = vld_s2;
	assign res_data  = res_s2;

endmodule

// ===== sv/elcb_step.sv =====
// Next-level arithmetic and bar graph decode for one request.
`timescale 1ns / 1ps

module elcb_step (
	input  logic [elcb_pkg::LevelW-1:0] level,
	input  elcb_pkg::req_t              req,
	input  elcb_pkg::cfg_t              cfg,
	output elcb_pkg::res_t              res
);
	import elcb_pkg::*;

	// 17x8 signed product plus level needs 24 bits; one spare
	localparam int unsigned SumW = 25;

	logic signed [DeltaW:0]   d_ext;
	logic        [DeltaW:0]   mag;
	logic        [7:0]        low_byte;
	logic signed [SumW-1:0]   d_w;
	logic signed [SumW-1:0]   lv_w;
	logic signed [SumW-1:0]   cs_w;
	logic signed [SumW-1:0]   prod;
	logic signed [SumW-1:0]   sum;
	logic        [LevelW-1:0] nxt;
	logic        [BarW-1:0]   bar;
	logic                     d_neg;
	logic                     d_pos;

	assign d_ext    = {req.delta[DeltaW-1], req.delta};
	assign d_neg    = req.delta[DeltaW-1];
	assign d_pos    = !d_neg && (req.delta != '0);
	assign mag      = d_neg ? (DeltaW+1)'(-d_ext) : d_ext;
	assign low_byte = d_neg ? mag[7:0] : req.delta[7:0];
	assign d_w      = SumW'(d_ext);
	assign lv_w     = $signed({{(SumW-LevelW){1'b0}}, level});
	assign cs_w     = $signed({{(SumW-7){1'b0}}, cfg.coarse_step});
	assign prod     = d_w * cs_w;

	always_comb begin
		sum = lv_w;
		unique case (cfg.mode)
			MODE_LINEAR: begin
				if (d_neg)
					sum = lv_w - $signed({{(SumW-8){1'b0}}, low_byte});
				else
					sum = lv_w + $signed({{(SumW-8){1'b0}}, low_byte});
			end
			MODE_THRESH: begin
				if (mag >= {{(DeltaW-7){1'b0}}, cfg.accel_threshold})
					sum = lv_w + prod;
				else
					sum = lv_w + d_w;
			end
			MODE_SINGLE: begin
				sum = lv_w + prod;
				// snap to an end when within one step of it
				if (sum < SumW'(LevelMax) && d_pos && (sum + cs_w) >= SumW'(LevelMax))
					sum = SumW'(LevelMax);
				else if (sum > 0 && d_neg && (sum - cs_w) <= 0)
					sum = '0;
			end
			default: sum = lv_w;
		endcase
	end

	always_comb begin
		if (req.kind)
			nxt = (cfg.start_level > LevelMax) ? LevelMax : cfg.start_level;
		else if (sum < 0)
			nxt = '0;
		else if (sum > SumW'(LevelMax))
			nxt = LevelMax;
		else
			nxt = sum[LevelW-1:0];
	end

	always_comb begin
		bar    = '0;
		bar[0] = (nxt != '0);
		for (int i = 1; i <= 8; i++) begin
			bar[i] = (nxt >= LevelW'(5 + 10 * i));
		end
		bar[9] = (nxt > 7'd99);
	end

	assign res.level   = nxt;
	assign res.led_bar = bar;

endmodule

// ===== sv/elcb_chk.sv =====
// Port-level checks for the level control block, bound to its top level.
`timescale 1ns / 1ps

module elcb_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_stall,
	input elcb_pkg::res_t res_data,
	input logic           res_valid,
	input logic           res_stall
);
	import elcb_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result dropped or changed while stalled");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.level <= LevelMax)
		else $error("level out of range");

	a_bar_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.led_bar[0] == (res_data.level != '0)) &&
			(res_data.led_bar[9] == (res_data.level == LevelMax)))
		else $error("bar graph end LEDs disagree with level");

	a_bar_fill: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.led_bar[BarW-1:1] & ~res_data.led_bar[BarW-2:0]) == '0)
		else $error("bar graph has a gap");

	// input stalls only when the result side is blocked too
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> res_valid && res_stall)
		else $error("request stalled with result side free");

endmodule

bind encoder_level_control_bargraph_top elcb_chk u_elcb_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.res_data  (res_data),
	.res_valid (res_valid),
	.res_stall (res_stall)
);
